// ===== src/mwto_pkg.sv =====
// Shared types, constants and the sine quarter-wave table builder
// for the multi-waveform tone oscillator. No dependencies.
`default_nettype none

package mwto_pkg;

    // Field and register widths
    localparam int SAMPLE_W     = 16;
    localparam int MODE_W       = 2;
    localparam int STEP_W       = 24;
    localparam int PEAK_W       = 15;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 24;
    localparam int MAG_W        = 16;   // wave magnitude, up to 32768
    localparam int WAVE_W       = 17;   // signed Q1.15 wave value
    localparam int PROD_W       = 32;

    localparam int PHASE_BITS_DEF = 24;

    // Quarter-wave sine table
    localparam int SINE_DEPTH    = 1024;
    localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH + 1);
    localparam longint PI_HALF_Q30 = 64'd1686629713;

    localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd3276;
    localparam logic [MAG_W-1:0]  SQUARE_MAG = 16'd16384;

    // Waveform codes
    localparam logic [MODE_W-1:0] MODE_SINE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_LEVEL = 1'd1;

    // Word passed from front to back through the queue
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic                     last;
        logic                     neg;     // wave value is negative
        logic [MAG_W-1:0]         mag;     // triangle/square magnitude
        logic [SINE_IDX_BITS-1:0] idx;     // sine table address
    } item_t;

    typedef logic [PEAK_W-1:0] sine_rom_t [0:SINE_DEPTH];

    // Q30 Taylor series to x^11, rounded to Q0.15
    function automatic sine_rom_t sine_rom_build();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x    = (64'(PI_HALF_Q30) * 64'(k)) / SINE_DEPTH;
            term = x;
            sum  = longint'(x);
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 6;
            sum  = sum - longint'(term);
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 20;
            sum  = sum + longint'(term);
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 42;
            sum  = sum - longint'(term);
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 72;
            sum  = sum + longint'(term);
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 110;
            sum  = sum - longint'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            rom[k] = v[PEAK_W-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== src/mwto_front.sv =====
// Front end: phase accumulator, accepts input words and works out the
// wave magnitude, sign and sine address. Uses mwto_pkg.
`default_nettype none

module mwto_front #(
    parameter int PHASE_BITS = mwto_pkg::PHASE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mwto_pkg::MODE_W-1:0]       in_mode,
    input  wire logic signed [mwto_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                              in_last,
    input  wire logic [mwto_pkg::STEP_W-1:0]       phase_step,
    input  wire logic                              q_ready,
    output logic                                   push,
    output mwto_pkg::item_t                        push_item
);

    localparam int RW = PHASE_BITS - 1;                      // quarter offset incl. Q
    localparam int PW = RW + mwto_pkg::SINE_IDX_BITS;        // index product width
    localparam int TW = RW + 15;                             // triangle scale width
    localparam logic [RW-1:0] QTR = {1'b1, {(PHASE_BITS - 2){1'b0}}};

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [1:0]            quad;
    logic [RW-1:0]         rofs;
    logic [RW-1:0]         rr;
    logic [PW-1:0]         idx_prod;
    logic [PW-1:0]         idx_full;
    logic [mwto_pkg::SINE_IDX_BITS-1:0] idx;
    logic [TW-1:0]         tri_wide;
    logic                  half_pos;     // phase <= half cycle

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    assign quad = phase_acc_reg[PHASE_BITS-1 -: 2];
    assign rofs = {1'b0, phase_acc_reg[PHASE_BITS-3:0]};

    // mirrored offset in 2nd/4th quarter; serves sine and triangle alike
    assign rr = quad[0] ? (QTR - rofs) : rofs;

    assign idx_prod = PW'(rr) * PW'(mwto_pkg::SINE_DEPTH);
    assign idx_full = idx_prod >> (PHASE_BITS - 2);

    always_comb
    begin
        if (idx_full > PW'(mwto_pkg::SINE_DEPTH))
        begin
            idx = mwto_pkg::SINE_IDX_BITS'(mwto_pkg::SINE_DEPTH);
        end
        else
        begin
            idx = idx_full[mwto_pkg::SINE_IDX_BITS-1:0];
        end
    end

    assign tri_wide = {rr, 15'b0} >> (PHASE_BITS - 2);
    assign half_pos = !quad[1] || (quad == 2'd2 && rofs == '0);

    always_comb
    begin
        push_item.mode   = in_mode;
        push_item.sample = in_sample;
        push_item.last   = in_last;
        push_item.idx    = idx;
        case (in_mode)
            mwto_pkg::MODE_SINE:
            begin
                push_item.mag = '0;
                push_item.neg = quad[1];
            end
            mwto_pkg::MODE_TRIANGLE:
            begin
                push_item.mag = tri_wide[mwto_pkg::MAG_W-1:0];
                push_item.neg = quad[1];
            end
            mwto_pkg::MODE_SQUARE:
            begin
                push_item.mag = mwto_pkg::SQUARE_MAG;
                push_item.neg = !half_pos;
            end
            default:
            begin
                push_item.mag = '0;   // silence
                push_item.neg = 1'b0;
            end
        endcase
    end

    assign phase_acc_next = phase_acc_reg + PHASE_BITS'(phase_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else if (push)
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !push |=> $stable(phase_acc_reg))
        else $error("phase moved without an accepted word");

endmodule

`default_nettype wire

// ===== src/mwto_queue.sv =====
// Two-entry queue between the front and back ends. Uses mwto_pkg.
`default_nettype none

module mwto_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mwto_pkg::item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output mwto_pkg::item_t      pop_item,
    input  wire logic            pop
);

    localparam int DEPTH = 2;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwto_pkg::item_t  mem_reg [0:DEPTH-1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== src/mwto_back.sv =====
// Back end: sine table read, scale by peak level, saturating add and
// output register. Uses mwto_pkg.
`default_nettype none

module mwto_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire mwto_pkg::item_t                   q_item,
    output logic                                   q_pop,
    input  wire logic [mwto_pkg::PEAK_W-1:0]       peak_level,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [mwto_pkg::SAMPLE_W-1:0]   out_sample,
    output logic                                   out_last
);

    localparam mwto_pkg::sine_rom_t SINE_ROM = mwto_pkg::sine_rom_build();
    localparam int SUM_W = mwto_pkg::SAMPLE_W + 2;
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (mwto_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    // stage A: table read
    logic                          va_reg;
    mwto_pkg::item_t               a_item_reg;
    logic [mwto_pkg::PEAK_W-1:0]   rom_q_reg;
    // stage B: product
    logic                          vb_reg;
    logic signed [mwto_pkg::SAMPLE_W-1:0] b_sample_reg;
    logic                          b_last_reg;
    logic signed [mwto_pkg::PROD_W-1:0] prod_reg;
    logic signed [mwto_pkg::PROD_W-1:0] prod_next;
    // stage C: output
    logic                          vc_reg;
    logic signed [mwto_pkg::SAMPLE_W-1:0] c_sample_reg;
    logic                          c_last_reg;
    logic signed [mwto_pkg::SAMPLE_W-1:0] c_sample_next;

    logic                          ready_a;
    logic                          ready_b;
    logic                          ready_c;
    logic [mwto_pkg::MAG_W-1:0]    mag;
    logic signed [mwto_pkg::WAVE_W-1:0] wave;
    logic [mwto_pkg::PROD_W-1:0]   prod_abs;
    logic [mwto_pkg::MAG_W-1:0]    scaled;
    logic signed [SUM_W-1:0]       sum;

    assign ready_c = !vc_reg || out_ready;
    assign ready_b = !vb_reg || ready_c;
    assign ready_a = !va_reg || ready_b;
    assign q_pop   = q_valid && ready_a;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_item_reg <= q_item;
            rom_q_reg  <= SINE_ROM[q_item.idx];
        end
    end

    always_comb
    begin
        if (a_item_reg.mode == mwto_pkg::MODE_SINE)
        begin
            mag = {1'b0, rom_q_reg};
        end
        else
        begin
            mag = a_item_reg.mag;
        end
        if (a_item_reg.neg)
        begin
            wave = -$signed({1'b0, mag});
        end
        else
        begin
            wave = $signed({1'b0, mag});
        end
        prod_next = mwto_pkg::PROD_W'(wave) * $signed({17'b0, peak_level});
    end

    always_ff @(posedge clk)
    begin
        if (va_reg && ready_b)
        begin
            b_sample_reg <= a_item_reg.sample;
            b_last_reg   <= a_item_reg.last;
            prod_reg     <= prod_next;
        end
    end

    // truncate toward zero, then saturating add
    assign prod_abs = prod_reg[mwto_pkg::PROD_W-1] ? 32'(-prod_reg) : 32'(prod_reg);
    assign scaled   = prod_abs[30:15];

    always_comb
    begin
        if (prod_reg[mwto_pkg::PROD_W-1])
        begin
            sum = SUM_W'(b_sample_reg) - $signed({2'b0, scaled});
        end
        else
        begin
            sum = SUM_W'(b_sample_reg) + $signed({2'b0, scaled});
        end
        if (sum > SMAX)
        begin
            c_sample_next = SMAX[mwto_pkg::SAMPLE_W-1:0];
        end
        else if (sum < SMIN)
        begin
            c_sample_next = SMIN[mwto_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            c_sample_next = sum[mwto_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vb_reg && ready_c)
        begin
            c_sample_reg <= c_sample_next;
            c_last_reg   <= b_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= q_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    assign out_valid  = vc_reg;
    assign out_sample = c_sample_reg;
    assign out_last   = c_last_reg;

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vc_reg) |-> $past(vb_reg))
        else $error("output word appeared without a product stage word");

endmodule

`default_nettype wire

// ===== src/multi_waveform_tone_oscillator_top.sv =====
// Multi-waveform tone oscillator top: front end, queue, back end, config regs.
// Input word accept to output tvalid passes queue, table, product and output registers.
// Throughput: one word per cycle without stalls; table read, multiply: one stage each.
// A 2-word queue decouples the phase front end from the arithmetic back end.
// Reset (async, active low): phase 0, phase_step 0, peak_level 3276, pipeline empty.
// Depends on mwto_pkg, mwto_front, mwto_queue, mwto_back.
`default_nettype none

module multi_waveform_tone_oscillator_top #(
    parameter int PHASE_BITS = mwto_pkg::PHASE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input words
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mwto_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] in_sample
    input  wire logic [mwto_pkg::MODE_W-1:0]         s_axis_tuser,   // [1:0] mode
    input  wire logic                                s_axis_tlast,   // last_of_buffer
    // output words
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [mwto_pkg::SAMPLE_W-1:0]            m_axis_tdata,   // [15:0] out_sample
    output logic                                     m_axis_tlast,   // last_out
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [mwto_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mwto_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [mwto_pkg::STEP_W-1:0] phase_step_reg;
    logic [mwto_pkg::PEAK_W-1:0] peak_level_reg;

    logic                        push;
    logic                        q_ready;
    mwto_pkg::item_t             push_item;
    logic                        q_valid;
    mwto_pkg::item_t             q_item;
    logic                        q_pop;
    logic signed [mwto_pkg::SAMPLE_W-1:0] out_sample;

    // Config registers; user must write only while the datapath is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            peak_level_reg <= mwto_pkg::PEAK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mwto_pkg::REG_PHASE_STEP:
                begin
                    phase_step_reg <= cfg_wdata[mwto_pkg::STEP_W-1:0];
                end
                mwto_pkg::REG_PEAK_LEVEL:
                begin
                    peak_level_reg <= cfg_wdata[mwto_pkg::PEAK_W-1:0];
                end
                default:
                begin
                    phase_step_reg <= phase_step_reg;
                end
            endcase
        end
    end

    // Front: phase accumulator and wave classification per word.
    mwto_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (s_axis_tuser),
        .in_sample  ($signed(s_axis_tdata)),
        .in_last    (s_axis_tlast),
        .phase_step (phase_step_reg),
        .q_ready    (q_ready),
        .push       (push),
        .push_item  (push_item)
    );

    // Short queue lets the front keep taking words while the back stalls, until full.
    mwto_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    // Back: sine table, peak scaling, saturating mix, output register.
    mwto_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .peak_level (peak_level_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = out_sample;

endmodule

`default_nettype wire

// ===== tb/tb_multi_waveform_tone_oscillator_top.sv =====
// Self-checking testbench for the multi-waveform tone oscillator: random and directed
// sample words with per-word waveform choice, checked against an in-bench tone predictor.
// Depends on mwto_pkg and multi_waveform_tone_oscillator_top.
`default_nettype none

module tb_multi_waveform_tone_oscillator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PH_W         = mwto_pkg::PHASE_BITS_DEF;
    localparam longint QTR          = 64'd1 << (PH_W - 2);   // quarter cycle
    localparam int     LIMIT_CYCLES = 400000;
    localparam int     LONG_HOLD    = 400;                    // receiver back-pressure run
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_WORDS  = 170;

    localparam logic [mwto_pkg::MODE_W-1:0] MODE_SILENT = 2'd3;   // unused code

    // One input word and one output word as the bench sees them
    typedef struct {
        logic [mwto_pkg::MODE_W-1:0]   mode;
        logic [mwto_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } tone_in_t;

    typedef struct {
        logic [mwto_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } tone_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [mwto_pkg::SAMPLE_W-1:0]     s_axis_tdata  = '0;   // [15:0] in_sample
    logic [mwto_pkg::MODE_W-1:0]       s_axis_tuser  = '0;   // [1:0] mode
    logic                              s_axis_tlast  = 1'b0; // last_of_buffer
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [mwto_pkg::SAMPLE_W-1:0]     m_axis_tdata;         // [15:0] out_sample
    logic                              m_axis_tlast;         // last_out
    logic                              cfg_we    = 1'b0;
    logic [mwto_pkg::CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [mwto_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    multi_waveform_tone_oscillator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tone predictor state: its own copy of the registers and the phase
    // ------------------------------------------------------------------
    int unsigned                 sine_q [0:mwto_pkg::SINE_DEPTH];   // Q0.15 magnitudes
    logic [PH_W-1:0]             tone_phase = '0;
    logic [mwto_pkg::STEP_W-1:0] tone_step  = '0;
    logic [mwto_pkg::PEAK_W-1:0] tone_peak  = mwto_pkg::PEAK_RESET;

    tone_in_t  pending_words[$];   // words waiting for the driver
    tone_out_t tone_expect[$];     // predicted output words, oldest first
    tone_in_t  word_on_bus;
    tone_out_t seen_word;
    tone_out_t want_word;

    int  err_count     = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  recv_hold     = 0;
    bit  send_idle     = 1'b0;   // sender inserts random gaps
    bit  recv_idle     = 1'b0;   // receiver inserts random stalls
    bit  hold_long_req = 1'b0;   // one-shot request for a long receiver stall

    // Taylor series in Q30 up to x^11, then rounded to 15 bits
    function automatic void build_sine_q();
        longint unsigned x;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int k = 0; k <= mwto_pkg::SINE_DEPTH; k++)
        begin
            x    = (longint'(mwto_pkg::PI_HALF_Q30) * k) / mwto_pkg::SINE_DEPTH;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767)
                v = 32767;
            sine_q[k] = int'(v);
        end
    endfunction

    function automatic longint sine_at(logic [PH_W-1:0] p);
        longint off;
        longint idx;
        longint v;
        off = longint'(p[PH_W-3:0]);
        if (p[PH_W-2])
            off = QTR - off;             // mirrored in 2nd and 4th quarter
        idx = (off * mwto_pkg::SINE_DEPTH) >> (PH_W - 2);
        if (idx > mwto_pkg::SINE_DEPTH)
            idx = mwto_pkg::SINE_DEPTH;
        v = longint'(sine_q[idx]);
        return p[PH_W-1] ? -v : v;       // negative half
    endfunction

    function automatic longint tri_at(logic [PH_W-1:0] p);
        longint pp;
        pp = longint'(p);
        if (pp <= QTR)
            return (pp << 15) >> (PH_W - 2);
        if (pp <= 3 * QTR)
        begin
            if (pp < 2 * QTR)
                return ((2 * QTR - pp) << 15) >> (PH_W - 2);
            return -(((pp - 2 * QTR) << 15) >> (PH_W - 2));
        end
        return -(((4 * QTR - pp) << 15) >> (PH_W - 2));
    endfunction

    // Scaled wave added to the sample, truncated toward zero, saturated
    function automatic tone_out_t mix_tone(tone_in_t w, logic [PH_W-1:0] p);
        longint    wave;
        longint    prod;
        longint    mag;
        longint    total;
        tone_out_t r;
        case (w.mode)
            mwto_pkg::MODE_SINE:     wave = sine_at(p);
            mwto_pkg::MODE_TRIANGLE: wave = tri_at(p);
            mwto_pkg::MODE_SQUARE:   wave = (longint'(p) <= 2 * QTR) ? 16384 : -16384;
            default:                 wave = 0;    // unused code: silence
        endcase
        prod  = wave * longint'(tone_peak);
        mag   = (prod < 0 ? -prod : prod) >> 15;
        total = longint'($signed(w.sample)) + (prod < 0 ? -mag : mag);
        if (total > 32767)
            total = 32767;
        if (total < -32768)
            total = -32768;
        r.sample = total[mwto_pkg::SAMPLE_W-1:0];
        r.last   = w.last;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            return 0;
        if (roll < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 30));
    endfunction

    // ------------------------------------------------------------------
    // Driver: a word accepted at this edge is predicted, then the
    // next pending word goes on the bus once the gap has run out.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      = 0;
            tone_phase    = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tone_expect.push_back(mix_tone(word_on_bus, tone_phase));
                tone_phase = tone_phase + tone_step;   // wraps mod one cycle
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    word_on_bus    = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= word_on_bus.sample;
                    s_axis_tuser  <= word_on_bus.mode;
                    s_axis_tlast  <= word_on_bus.last;
                    send_gap       = pick_gap(send_idle);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long stall on request so the
    // pipeline and its queue fill up and tready drops on the input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold     = 0;
        end
        else if (hold_long_req)
        begin
            hold_long_req  = 1'b0;
            recv_hold      = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_hold      = pick_gap(recv_idle);
        end
    end

    // Monitor: every accepted output word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_word.sample = m_axis_tdata;
            seen_word.last   = m_axis_tlast;
            if (tone_expect.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected word: expected none, got sample %0d last %0b",
                         $time, $signed(seen_word.sample), seen_word.last);
            end
            else
            begin
                want_word = tone_expect.pop_front();
                if (seen_word.sample !== want_word.sample)
                begin
                    err_count++;
                    $display("%0t: out_sample mismatch: expected %0d, got %0d",
                             $time, $signed(want_word.sample),
                             $signed(seen_word.sample));
                end
                if (seen_word.last !== want_word.last)
                begin
                    err_count++;
                    $display("%0t: last_out mismatch: expected %0b, got %0b",
                             $time, want_word.last, seen_word.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // Both registers, written back to back while the block is idle
    task automatic set_tone(input logic [mwto_pkg::STEP_W-1:0] step,
                            input logic [mwto_pkg::PEAK_W-1:0] peak);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= mwto_pkg::REG_PHASE_STEP;
        cfg_wdata <= step;
        tone_step  = step;
        @(posedge clk);
        cfg_addr  <= mwto_pkg::REG_PEAK_LEVEL;
        cfg_wdata <= mwto_pkg::CFG_DATA_W'(peak);
        tone_peak  = peak;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Idle means nothing queued, nothing on the bus and nothing predicted
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || tone_expect.size() != 0);
    endtask

    function automatic tone_in_t rand_word();
        tone_in_t w;
        int       roll;
        roll = int'($urandom_range(0, 9));
        if (roll < 3)
            w.mode = mwto_pkg::MODE_SINE;
        else if (roll < 6)
            w.mode = mwto_pkg::MODE_TRIANGLE;
        else if (roll < 9)
            w.mode = mwto_pkg::MODE_SQUARE;
        else
            w.mode = MODE_SILENT;
        case ($urandom_range(0, 11))
            0:       w.sample = 16'h7FFF;
            1:       w.sample = 16'h8000;
            2:       w.sample = 16'h0000;
            3:       w.sample = 16'hFFFF;
            default: w.sample = mwto_pkg::SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
        w.last = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    initial
    begin
        tone_in_t                    w;
        logic [mwto_pkg::STEP_W-1:0] step;
        logic [mwto_pkg::PEAK_W-1:0] peak;

        build_sine_q();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: step 0, peak 3276, so the phase sits at zero
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int m = 0; m < 4; m++)
        begin
            w.mode   = mwto_pkg::MODE_W'(m);
            w.sample = 16'h0100;
            w.last   = (m == 3);
            pending_words.push_back(w);
        end
        wait_drained();

        // Directed: sixteenth-cycle steps land exactly on the
        // quarter boundaries; full peak with extreme samples to saturate
        set_tone(mwto_pkg::STEP_W'(1) << 20, 15'h7FFF);
        for (int i = 0; i < 21; i++)
        begin
            w.mode = mwto_pkg::MODE_W'((i + i / 4) % 4);
            case (i % 6)
                0:       w.sample = 16'h7FFF;
                1:       w.sample = 16'h8000;
                2:       w.sample = 16'h0000;
                3:       w.sample = 16'hFFFF;
                4:       w.sample = 16'h5555;
                default: w.sample = 16'hAAAA;
            endcase
            w.last = (i % 5 == 4);
            pending_words.push_back(w);
        end
        wait_drained();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    step = mwto_pkg::STEP_W'(1) << 20;
                    peak = mwto_pkg::PEAK_W'($urandom_range(0, 16'h7FFF));
                end
                1:
                begin
                    step = 24'hFFFFFF;
                    peak = 15'h7FFF;
                end
                2:
                begin
                    step = '0;
                    peak = '0;
                end
                3:
                begin
                    step = mwto_pkg::STEP_W'($urandom);
                    peak = mwto_pkg::PEAK_W'($urandom_range(0, 16'h7FFF));
                end
                4:
                begin
                    step = mwto_pkg::STEP_W'(1) << 22;
                    peak = 15'h7FFF;
                end
                5:
                begin
                    step = mwto_pkg::STEP_W'($urandom_range(1, 4095));
                    peak = mwto_pkg::PEAK_W'($urandom_range(0, 16'h7FFF));
                end
                6:
                begin
                    step = mwto_pkg::STEP_W'($urandom);
                    peak = 15'd1;
                end
                default:
                begin
                    step = mwto_pkg::STEP_W'($urandom);
                    peak = mwto_pkg::PEAK_W'($urandom_range(0, 16'h7FFF));
                end
            endcase
            set_tone(step, peak);

            send_idle = ($urandom_range(0, 1) == 1);
            recv_idle = ($urandom_range(0, 1) == 1);
            if (ph == 3)
            begin
                // sender keeps offering while the receiver holds off
                send_idle     = 1'b0;
                hold_long_req = 1'b1;
            end
            if (ph == 4)
            begin
                // full-rate stretch on both sides
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
                pending_words.push_back(rand_word());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0 && tone_expect.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
